[rtl/alist_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alist_pkg
// Shared constants and command codes for the ordered list engine.
// ----------------------------------------------------------------------------
package alist_pkg;

	localparam int CAPACITY = 128;

	localparam int DataW  = 32;
	localparam int PosW   = 8;
	localparam int AddrW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CountW = $clog2(CAPACITY + 1);
	// compare width: holds count + 1 and any position without overflow
	localparam int CmpW   = ((CountW > PosW) ? CountW : PosW) + 1;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

endpackage : alist_pkg
`default_nettype wire

[rtl/array_list_engine_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_engine_core
// Ordered list of signed 32-bit elements held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive command, position and value and raise start. The
//   request is taken at a rising edge where start is high and busy is low.
//   Commands: insert at a 1-based position, delete at a position (returns the
//   element), get at a position, locate the first position holding a value.
//   Result channel: done pulses high for exactly one cycle with status,
//   element, found_position and count valid in that cycle. The receiver
//   cannot stall; every result must be captured in its done cycle.
// Operation:
//   A rejected request (bad position or full list) is answered in the cycle after
//   the accepting edge. Otherwise the RAM is walked one entry per cycle through its
//   read port, with the write port storing each entry from the registered read
//   data: insert moves the entries from the tail down to the position one place
//   up, delete moves the entries after it one place down, get reads one entry and
//   locate stops at the first hit. The finish state writes an inserted element
//   and registers the result. One request is in flight at a time; busy is high meanwhile.
// Reset:
//   arst_n clears the element count and the control state. The RAM itself is
//   not cleared: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module array_list_engine_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  alist_pkg::cmd_t                command,
	input  wire  [alist_pkg::PosW-1:0]     position,
	input  wire  signed [alist_pkg::DataW-1:0] value,
	output logic                           done,
	output logic                           status,
	output logic signed [alist_pkg::DataW-1:0] element,
	output logic [alist_pkg::PosW-1:0]     found_position,
	output logic [alist_pkg::PosW-1:0]     count
);
	import alist_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// list storage: one write port, one registered read port
	logic [DataW-1:0] mem [CAPACITY];
	logic [DataW-1:0] rd_q;

	logic             mem_re;
	logic [AddrW-1:0] mem_raddr;
	logic             mem_we;
	logic [AddrW-1:0] mem_waddr;
	logic [DataW-1:0] mem_wdata;

	// control and working registers
	state_t            state_q;
	cmd_t              op_q;
	logic [DataW-1:0]  val_q;
	logic [AddrW-1:0]  base_q;     // position - 1
	logic [AddrW-1:0]  src_q;      // next RAM address to read
	logic [CountW-1:0] left_q;     // reads still to issue
	logic              first_q;    // next read is the first of the walk
	logic [CountW-1:0] count_q;
	logic [DataW-1:0]  elem_q;
	logic [PosW-1:0]   found_q;

	// read-data stage: describes the read whose data sits in rd_q
	logic              pend_s1;
	logic [AddrW-1:0]  src_s1;
	logic              first_s1;

	// result registers
	logic              done_q;
	logic              res_status_q;
	logic [DataW-1:0]  res_element_q;
	logic [PosW-1:0]   res_found_q;
	logic [PosW-1:0]   res_count_q;

	// request decode
	logic [CmpW-1:0]   pos_w;
	logic [CmpW-1:0]   cnt_w;
	logic              req_ok;

	logic              walking;
	logic              hit;
	logic              issue;

	always_comb begin
		pos_w = CmpW'(position);
		cnt_w = CmpW'(count_q);
		unique case (command)
			CMD_INSERT: req_ok = (pos_w != '0) && (pos_w <= cnt_w + CmpW'(1))
				&& (cnt_w < CmpW'(CAPACITY));
			CMD_DELETE,
			CMD_GET:    req_ok = (pos_w != '0) && (pos_w <= cnt_w);
			CMD_LOCATE: req_ok = 1'b1;
			default:    req_ok = 1'b0;
		endcase
	end

	// walk control: a locate hit stops the walk; otherwise issue while reads remain
	always_comb begin
		walking = (state_q == ST_WALK);
		hit     = walking && pend_s1 && (op_q == CMD_LOCATE) && (rd_q == val_q);
		issue   = walking && (left_q != '0) && !hit;
	end

	// RAM port decode
	always_comb begin
		mem_re    = issue;
		mem_raddr = src_q;
		mem_we    = 1'b0;
		mem_waddr = src_s1;
		mem_wdata = rd_q;
		if (walking && pend_s1) begin
			// shift up: entry moves one place higher
			if (op_q == CMD_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = src_s1 + AddrW'(1);
			end
			// shift down: every entry after the removed one moves one place lower
			if (op_q == CMD_DELETE && !first_s1) begin
				mem_we    = 1'b1;
				mem_waddr = src_s1 - AddrW'(1);
			end
		end
		// drop the new element into the opened slot
		if (state_q == ST_FINISH && op_q == CMD_INSERT) begin
			mem_we    = 1'b1;
			mem_waddr = base_q;
			mem_wdata = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// sequencer: state, working registers and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			pend_s1  <= 1'b0;
			first_q  <= 1'b0;
			first_s1 <= 1'b0;
			left_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					done_q  <= start && !req_ok;
					if (start) begin
						op_q    <= command;
						val_q   <= $unsigned(value);
						base_q  <= AddrW'(pos_w - CmpW'(1));
						elem_q  <= '0;
						found_q <= '0;
						first_q <= 1'b1;
						if (!req_ok) begin
							// reject at once, list untouched
							res_status_q  <= 1'b1;
							res_element_q <= '0;
							res_found_q   <= '0;
							res_count_q   <= PosW'(count_q);
						end else begin
							state_q <= ST_WALK;
							unique case (command)
								CMD_INSERT: begin
									src_q  <= AddrW'(cnt_w - CmpW'(1));
									left_q <= CountW'(cnt_w - pos_w + CmpW'(1));
								end
								CMD_DELETE: begin
									src_q  <= AddrW'(pos_w - CmpW'(1));
									left_q <= CountW'(cnt_w - pos_w + CmpW'(1));
								end
								CMD_GET: begin
									src_q  <= AddrW'(pos_w - CmpW'(1));
									left_q <= CountW'(1);
								end
								CMD_LOCATE: begin
									src_q  <= '0;
									left_q <= count_q;
								end
								default: begin
									src_q  <= '0;
									left_q <= '0;
								end
							endcase
						end
					end
				end
				ST_WALK: begin
					done_q <= 1'b0;
					if (issue) begin
						src_q    <= (op_q == CMD_INSERT) ? src_q - AddrW'(1)
							: src_q + AddrW'(1);
						left_q   <= left_q - CountW'(1);
						pend_s1  <= 1'b1;
						src_s1   <= src_q;
						first_s1 <= first_q;
						first_q  <= 1'b0;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && first_s1
						&& (op_q == CMD_DELETE || op_q == CMD_GET)) begin
						elem_q <= rd_q;
					end
					if (hit) begin
						found_q <= PosW'(CmpW'(src_s1) + CmpW'(1));
						state_q <= ST_FINISH;
					end else if (left_q == '0 && !pend_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					pend_s1       <= 1'b0;
					done_q        <= 1'b1;
					res_status_q  <= 1'b0;
					res_element_q <= elem_q;
					res_found_q   <= found_q;
					if (op_q == CMD_INSERT) begin
						count_q     <= count_q + CountW'(1);
						res_count_q <= PosW'(count_q + CountW'(1));
					end else if (op_q == CMD_DELETE) begin
						count_q     <= count_q - CountW'(1);
						res_count_q <= PosW'(count_q - CountW'(1));
					end else begin
						res_count_q <= PosW'(count_q);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign status         = res_status_q;
	assign element        = $signed(res_element_q);
	assign found_position = res_found_q;
	assign count          = res_count_q;

`ifndef NO_ASSERTIONS
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while engine busy");

	a_request_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request neither rejected nor started");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(CAPACITY))
		else $error("element count above capacity");

	a_count_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> done)
		else $error("element count changed without a result");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> element == '0 && found_position == '0)
		else $error("rejected request carries data");
`endif

endmodule : array_list_engine_core
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list engine. Requests go through the
// start/busy handshake, a shadow list in the bench predicts every answer, and
// each done strobe is compared field by field against the oldest owed answer.
// ----------------------------------------------------------------------------
module tb_top;
	import alist_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles   = CAPACITY + 8;

	typedef struct packed {
		logic             status;
		logic [DataW-1:0] element;
		logic [PosW-1:0]  found_position;
		logic [PosW-1:0]  count;
	} list_answer_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	cmd_t                    command;
	logic [PosW-1:0]         position;
	logic signed [DataW-1:0] value;
	logic                    done;
	logic                    status;
	logic signed [DataW-1:0] element;
	logic [PosW-1:0]         found_position;
	logic [PosW-1:0]         count;

	// shadow copy of the list held by the engine
	logic [DataW-1:0] shadow_list [CAPACITY];
	int               shadow_len;

	list_answer_t owed_answers [$];

	int failures;
	int requests_sent;
	int answers_checked;
	int peak_len;
	int full_rejects;
	int locate_hits;
	int sender_idle_pct;
	int quiet_cycles;

	array_list_engine_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.position       (position),
		.value          (value),
		.done           (done),
		.status         (status),
		.element        (element),
		.found_position (found_position),
		.count          (count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Apply one accepted request to the shadow list and return the answer the
	// engine owes for it.
	function automatic list_answer_t apply_list_op(input cmd_t cmd,
			input logic [PosW-1:0] pos, input logic [DataW-1:0] val);
		list_answer_t ans;
		int p;
		ans = '0;
		p = int'(pos);
		case (cmd)
			CMD_INSERT: begin
				// reject a position outside 1..len+1 or a full list
				if (p < 1 || p > shadow_len + 1 || shadow_len >= CAPACITY) begin
					ans.status = 1'b1;
					if (shadow_len >= CAPACITY)
						full_rejects++;
				end else begin
					for (int j = shadow_len; j >= p; j--)
						shadow_list[j] = shadow_list[j - 1];
					shadow_list[p - 1] = val;
					shadow_len++;
				end
			end
			CMD_DELETE: begin
				if (p < 1 || p > shadow_len) begin
					ans.status = 1'b1;
				end else begin
					ans.element = shadow_list[p - 1];
					for (int j = p; j < shadow_len; j++)
						shadow_list[j - 1] = shadow_list[j];
					shadow_len--;
				end
			end
			CMD_GET: begin
				if (p < 1 || p > shadow_len)
					ans.status = 1'b1;
				else
					ans.element = shadow_list[p - 1];
			end
			default: begin
				// locate ignores position; first match wins
				for (int j = 0; j < shadow_len; j++)
					if (ans.found_position == 0 && shadow_list[j] == val)
						ans.found_position = PosW'(j + 1);
				if (ans.found_position != 0)
					locate_hits++;
			end
		endcase
		ans.count = PosW'(shadow_len);
		if (shadow_len > peak_len)
			peak_len = shadow_len;
		return ans;
	endfunction

	// Values: a small pool for duplicates, copies of stored elements, or any word.
	function automatic logic [DataW-1:0] pick_value();
		case ($urandom_range(3))
			0: return 32'($urandom_range(7)) - 32'd4;
			1: return (shadow_len > 0) ? shadow_list[$urandom_range(shadow_len - 1)] : $urandom;
			default: return $urandom;
		endcase
	endfunction

	// Hold start low for a random gap; long gaps let the engine go idle first.
	task automatic sender_pause();
		int gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(140, 1) : $urandom_range(3, 1);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
	endtask

	// Drive one request and hold it until the engine takes it. start stays high
	// on return so back-to-back requests need no extra edge.
	task automatic send_request(input cmd_t cmd, input logic [PosW-1:0] pos,
			input logic [DataW-1:0] val);
		sender_pause();
		@(negedge clk);
		start    <= 1'b1;
		command  <= cmd;
		position <= pos;
		value    <= val;
		do
			@(posedge clk);
		while (busy);
		owed_answers.push_back(apply_list_op(cmd, pos, val));
		requests_sent++;
	endtask

	// Boundary positions, signed extremes, duplicates and the bad-position error paths.
	task automatic test_directed_edges();
		send_request(CMD_GET,    8'd1,   32'd0);
		send_request(CMD_DELETE, 8'd1,   32'd0);
		send_request(CMD_LOCATE, 8'd0,   32'd0);
		send_request(CMD_INSERT, 8'd0,   32'd5);
		send_request(CMD_INSERT, 8'd2,   32'd5);
		send_request(CMD_INSERT, 8'd1,   32'h8000_0000);
		send_request(CMD_INSERT, 8'd2,   32'h7FFF_FFFF);
		send_request(CMD_INSERT, 8'd1,   32'hFFFF_FFFF);
		send_request(CMD_INSERT, 8'd5,   32'd9);
		send_request(CMD_INSERT, 8'd255, 32'd9);
		send_request(CMD_INSERT, 8'd4,   32'd0);
		send_request(CMD_GET,    8'd0,   32'd0);
		send_request(CMD_GET,    8'd4,   32'd0);
		send_request(CMD_GET,    8'd5,   32'd0);
		send_request(CMD_LOCATE, 8'd255, 32'h7FFF_FFFF);
		send_request(CMD_LOCATE, 8'd3,   32'd1);
		send_request(CMD_LOCATE, 8'd1,   32'd0);
		send_request(CMD_INSERT, 8'd2,   32'hFFFF_FFFF);
		send_request(CMD_LOCATE, 8'd0,   32'hFFFF_FFFF);
		send_request(CMD_DELETE, 8'd0,   32'd0);
		send_request(CMD_DELETE, 8'd6,   32'd0);
		send_request(CMD_DELETE, 8'd5,   32'd0);
		send_request(CMD_DELETE, 8'd1,   32'd0);
		send_request(CMD_GET,    8'd1,   32'd0);
		send_request(CMD_DELETE, 8'd255, 32'd0);
	endtask

	// Fill to capacity, hammer the full list, then drain it to empty.
	task automatic test_fill_to_capacity();
		while (shadow_len < CAPACITY)
			send_request(CMD_INSERT, PosW'($urandom_range(shadow_len + 1, 1)), pick_value());
		send_request(CMD_INSERT, 8'd1, pick_value());
		send_request(CMD_INSERT, PosW'(CAPACITY + 1), pick_value());
		send_request(CMD_INSERT, PosW'($urandom_range(CAPACITY, 2)), pick_value());
		send_request(CMD_INSERT, 8'd0, pick_value());
		send_request(CMD_GET, PosW'(CAPACITY), 32'd0);
		send_request(CMD_GET, PosW'(CAPACITY + 1), 32'd0);
		send_request(CMD_LOCATE, 8'd0, shadow_list[CAPACITY - 1]);
		send_request(CMD_LOCATE, 8'd0, $urandom);
		while (shadow_len > 0) begin
			if ($urandom_range(7) == 0)
				send_request(CMD_GET, PosW'($urandom_range(shadow_len, 1)), $urandom);
			else
				send_request(CMD_DELETE, PosW'($urandom_range(shadow_len, 1)), $urandom);
		end
		send_request(CMD_DELETE, 8'd1, 32'd0);
	endtask

	// Mostly well-formed traffic steered toward a wandering fill level, plus
	// a slice of raw noise and out-of-range positions.
	task automatic test_random_traffic(input int n_requests);
		int   fill_goal;
		int   w_ins;
		int   w_del;
		int   pick;
		int   top_pos;
		cmd_t cmd;
		logic [PosW-1:0] pos;
		fill_goal = 0;
		for (int i = 0; i < n_requests; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(3))
					0: fill_goal = 0;
					1: fill_goal = CAPACITY;
					default: fill_goal = $urandom_range(CAPACITY);
				endcase
			end
			if ($urandom_range(99) < 8) begin
				send_request(cmd_t'($urandom_range(3)), PosW'($urandom_range(255)), $urandom);
			end else begin
				w_ins = (shadow_len < fill_goal) ? 45 : 15;
				w_del = (shadow_len > fill_goal) ? 45 : 15;
				pick = $urandom_range(w_ins + w_del + 39);
				if (pick < w_ins)
					cmd = CMD_INSERT;
				else if (pick < w_ins + w_del)
					cmd = CMD_DELETE;
				else if (pick < w_ins + w_del + 20)
					cmd = CMD_GET;
				else
					cmd = CMD_LOCATE;
				top_pos = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
				if (top_pos == 0 || $urandom_range(9) == 0)
					pos = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, top_pos + 1));
				else
					pos = PosW'($urandom_range(top_pos, 1));
				send_request(cmd, pos, pick_value());
			end
		end
	endtask

	// Score every done strobe against the oldest owed answer.
	always @(posedge clk) begin : check_answers
		list_answer_t want;
		if (arst_n && done) begin
			if (owed_answers.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				want = owed_answers.pop_front();
				answers_checked++;
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
				if (element !== want.element) begin
					$error("element: expected %08h, got %08h", want.element, element);
					failures++;
				end
				if (found_position !== want.found_position) begin
					$error("found_position: expected %0d, got %0d", want.found_position,
						found_position);
					failures++;
				end
				if (count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, count);
					failures++;
				end
			end
		end
	end

	// Abort when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: no request taken and no result for %0d cycles", quiet_cycles);
			$display("FAIL array_list_engine_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		command         = CMD_INSERT;
		position        = '0;
		value           = '0;
		shadow_len      = 0;
		failures        = 0;
		requests_sent   = 0;
		answers_checked = 0;
		peak_len        = 0;
		full_rejects    = 0;
		locate_hits     = 0;
		sender_idle_pct = 9;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// light sender gaps
		test_directed_edges();
		test_fill_to_capacity();
		test_random_traffic(250);
		// heavy sender gaps
		sender_idle_pct = 72;
		test_random_traffic(250);
		// back-to-back requests
		sender_idle_pct = 0;
		test_random_traffic(250);
		test_fill_to_capacity();

		@(negedge clk);
		start <= 1'b0;
		while (owed_answers.size() != 0)
			@(posedge clk);
		// hold long enough to catch any stray strobe
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d requests, checked %0d results; list peaked at %0d of %0d entries.",
			requests_sent, answers_checked, peak_len, CAPACITY);
		$display("Inserts refused on a full list: %0d, locates that hit: %0d.",
			full_rejects, locate_hits);
		if (failures == 0)
			$display("PASS array_list_engine_core");
		else
			$display("FAIL array_list_engine_core");
		$finish;
	end

endmodule : tb_top
